[rtl/timespec_sleep_timer_defines.svh]
// Assertion macros for the checker file.
`ifndef TIMESPEC_SLEEP_TIMER_DEFINES_SVH
`define TIMESPEC_SLEEP_TIMER_DEFINES_SVH

// Checks that a property holds on every rising clock edge outside reset.
`define TST_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checks a property during reset as well.
`define TST_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/tst_pkg.sv]
`default_nettype none
package tst_pkg;

    localparam logic [31:0] NANOS_PER_SEC = 32'd1000000000;
    localparam logic [31:0] MAX_NSEC = NANOS_PER_SEC - 32'd1;
    localparam logic [31:0] FREQ_RESET = 32'd19200000;
    localparam logic [62:0] SEC_MAX_63 = {63{1'b1}};
    // Dividend for the seconds limit: the 64-bit maximum less 999999999.
    localparam logic [63:0] DIVIDEND_MAX = 64'hFFFF_FFFF_FFFF_FFFF - 64'd999999999;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_SLEEP = 2'd1;
    localparam logic [1:0] REQ_INTR  = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_INTR    = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic               relative;
        logic signed [63:0] req_seconds;
        logic signed [31:0] req_nanoseconds;
    } tst_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [62:0] rem_seconds;
        logic [29:0] rem_nanoseconds;
    } tst_out_t;

endpackage
`default_nettype wire

[rtl/timespec_sleep_timer.sv]
// Channel   Direction  Handshake               Payload
// s_        in         s_valid / s_ready       tst_in_t
// m_        out        m_valid / m_ready       tst_out_t
// cfg_      in         cfg_valid / cfg_ready   tick_frequency (32 bits)
// A tick, an unused item or an interrupt while not armed is handled in the idle state. A
// sleep request goes through a 64-step divide for the seconds limit, a check, two 32-step
// multiplies, a 64-step divide by 1e9 and a compare; an invalid one ends after the check.
// An interrupt while armed runs two 64-step divides and one 32-step multiply, all on the
// one bit-serial unit. Reset is synchronous, active low. A result waits in the output
// register and holds off input.
`default_nettype none
module timespec_sleep_timer
    import tst_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire tst_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output tst_out_t      m_data,
    input  wire logic     cfg_valid,
    output logic          cfg_ready,
    input  wire logic [31:0] cfg_data
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MAXS  = 9'b000000010,  // max_sec = DIVIDEND_MAX / f
        S_CHECK = 9'b000000100,
        S_MULA  = 9'b000001000,  // sec[31:0] * f
        S_MULB  = 9'b000010000,  // ns * f
        S_DIVN  = 9'b000100000,  // (ns * f) / 1e9, also rem / f
        S_FIN   = 9'b001000000,
        S_MULR  = 9'b010000000,  // (rem mod f) * 1e9
        S_DIVR  = 9'b100000000   // that product / f
    } state_t;

    state_t       state_reg, state_next;
    logic [31:0]  freq_reg;
    logic [63:0]  cur_reg, dl_reg;
    logic         armed_reg;
    logic         out_valid_reg;
    tst_out_t     out_reg;
    tst_in_t      req_reg;
    logic         intr_reg;

    // Shared shift-add/subtract unit.
    logic [63:0]  acc_reg;    // divide remainder
    logic [63:0]  quo_reg;    // divide dividend shifting into quotient
    logic [31:0]  mpl_reg;    // multiplier bits
    logic [95:0]  mcd_reg;    // shifted multiplicand
    logic [6:0]   cnt_reg;
    logic [63:0]  maxs_reg, prod_reg, secq_reg;

    logic [31:0]  f_eff;
    assign f_eff = (freq_reg == 32'd0) ? 32'd1 : freq_reg;

    logic         busy;
    assign busy = (state_reg != S_IDLE);
    assign s_ready = !busy && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

    // Restoring divide step on the remainder and dividend registers.
    logic [64:0]  div_trial;
    logic [64:0]  div_rem_sh;
    logic [31:0]  div_sor;
    assign div_sor = (state_reg == S_DIVN && !intr_reg) ? NANOS_PER_SEC : f_eff;
    assign div_rem_sh = {acc_reg, quo_reg[63]};
    assign div_trial = div_rem_sh - {33'd0, div_sor};

    logic [63:0]  sec_u;
    logic [31:0]  ns_u;
    logic         bad;
    logic [63:0]  dl_sum;
    logic [63:0]  rem_t;
    assign sec_u = req_reg.req_seconds;
    assign ns_u = req_reg.req_nanoseconds;
    assign bad = req_reg.req_seconds[63] || (sec_u > maxs_reg)
                 || ns_u[31] || (ns_u > MAX_NSEC);
    assign dl_sum = secq_reg + quo_reg + (req_reg.relative ? cur_reg : 64'd0);
    assign rem_t = (dl_reg > cur_reg) ? dl_reg - cur_reg : 64'd0;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_valid && s_ready) begin
                         if (s_data.req_type == REQ_SLEEP) state_next = S_MAXS;
                         else if (s_data.req_type == REQ_INTR && armed_reg)
                             state_next = S_DIVN;
                     end
            S_MAXS:  if (cnt_reg == 7'd63) state_next = S_CHECK;
            S_CHECK: state_next = bad ? S_IDLE : S_MULA;
            S_MULA:  if (cnt_reg == 7'd31) state_next = S_MULB;
            S_MULB:  if (cnt_reg == 7'd31) state_next = S_DIVN;
            S_DIVN:  if (cnt_reg == 7'd63) state_next = intr_reg ? S_MULR : S_FIN;
            S_FIN:   state_next = S_IDLE;
            S_MULR:  if (cnt_reg == 7'd31) state_next = S_DIVR;
            S_DIVR:  if (cnt_reg == 7'd63) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            freq_reg      <= FREQ_RESET;
            cur_reg       <= 64'd0;
            dl_reg        <= 64'd0;
            armed_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= 7'd0;
            intr_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) freq_reg <= cfg_data;
            if (m_valid && m_ready) out_valid_reg <= 1'b0;
            cnt_reg <= (state_next != state_reg) ? 7'd0 : cnt_reg + 7'd1;
            case (state_reg)
                S_IDLE: if (s_valid && s_ready) begin
                    req_reg  <= s_data;
                    intr_reg <= (s_data.req_type == REQ_INTR);
                    if (s_data.req_type == REQ_TICK) begin
                        cur_reg <= cur_reg + 64'd1;
                        if (armed_reg && (cur_reg + 64'd1) >= dl_reg) begin
                            armed_reg     <= 1'b0;
                            out_valid_reg <= 1'b1;
                            out_reg       <= '{ST_DONE, 63'd0, 30'd0};
                        end
                    end else if (s_data.req_type == REQ_SLEEP) begin
                        acc_reg <= 64'd0;
                        quo_reg <= DIVIDEND_MAX;
                    end else if (s_data.req_type == REQ_INTR && armed_reg) begin
                        acc_reg <= 64'd0;
                        quo_reg <= rem_t;
                    end
                end
                S_MAXS, S_DIVN, S_DIVR: begin
                    if (!div_trial[64]) begin
                        acc_reg <= div_trial[63:0];
                        quo_reg <= {quo_reg[62:0], 1'b1};
                    end else begin
                        acc_reg <= div_rem_sh[63:0];
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                    if (cnt_reg == 7'd63) begin
                        if (state_reg == S_MAXS) begin
                            maxs_reg <= div_trial[64] ? {quo_reg[62:0], 1'b0}
                                                      : {quo_reg[62:0], 1'b1};
                        end else if (state_reg == S_DIVN && intr_reg) begin
                            secq_reg <= div_trial[64] ? {quo_reg[62:0], 1'b0}
                                                      : {quo_reg[62:0], 1'b1};
                            mpl_reg  <= NANOS_PER_SEC;
                            mcd_reg  <= {32'd0, (div_trial[64] ? div_rem_sh[63:0]
                                                               : div_trial[63:0])};
                            prod_reg <= 64'd0;
                        end else if (state_reg == S_DIVR) begin
                            armed_reg     <= 1'b0;
                            out_valid_reg <= 1'b1;
                            out_reg.status <= ST_INTR;
                            out_reg.rem_seconds <= secq_reg[63] ? SEC_MAX_63
                                                               : secq_reg[62:0];
                            out_reg.rem_nanoseconds <= div_trial[64]
                                ? {quo_reg[28:0], 1'b0} : {quo_reg[28:0], 1'b1};
                        end
                    end
                end
                S_CHECK: begin
                    if (maxs_reg[63]) maxs_reg <= {1'b0, SEC_MAX_63};
                    if (bad) begin
                        out_valid_reg <= 1'b1;
                        out_reg <= '{ST_INVALID, 63'd0, 30'd0};
                    end
                    mpl_reg  <= req_reg.req_seconds[31:0];
                    mcd_reg  <= {64'd0, f_eff};
                    prod_reg <= 64'd0;
                end
                S_MULA, S_MULB, S_MULR: begin
                    if (mpl_reg[0]) prod_reg <= prod_reg + mcd_reg[63:0];
                    mpl_reg <= {1'b0, mpl_reg[31:1]};
                    mcd_reg <= {mcd_reg[94:0], 1'b0};
                    if (cnt_reg == 7'd31) begin
                        if (state_reg == S_MULA) begin
                            // The nanosecond product starts from a clear accumulator.
                            mpl_reg  <= ns_u;
                            mcd_reg  <= {64'd0, f_eff};
                            prod_reg <= 64'd0;
                            secq_reg <= prod_reg + (mpl_reg[0] ? mcd_reg[63:0] : 64'd0);
                        end else begin
                            acc_reg <= 64'd0;
                            quo_reg <= prod_reg + (mpl_reg[0] ? mcd_reg[63:0] : 64'd0);
                        end
                    end
                end
                S_FIN: begin
                    if (dl_sum <= cur_reg) begin
                        armed_reg     <= 1'b0;
                        out_valid_reg <= 1'b1;
                        out_reg       <= '{ST_DONE, 63'd0, 30'd0};
                    end else begin
                        dl_reg    <= dl_sum;
                        armed_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/tst_checker.sv]
`default_nettype none
`include "timespec_sleep_timer_defines.svh"
module tst_checker
    import tst_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_ready,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire tst_out_t m_data
);
    `TST_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result dropped while stalled")
    `TST_ASSERT(a_no_take_full, aclk, aresetn, m_valid |-> !s_ready, "item taken while result waits")
    `TST_ASSERT(a_status_code, aclk, aresetn, m_valid |-> m_data.status != 2'd3, "bad status code")
    `TST_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_valid, "result after reset")
endmodule

bind timespec_sleep_timer tst_checker u_tst_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
`default_nettype wire

[bench/testbench.sv]
`default_nettype none
module testbench;
    import tst_pkg::*;

    logic          aclk;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    tst_in_t       s_data;
    logic          m_valid;
    logic          m_ready;
    tst_out_t      m_data;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [31:0]   cfg_data;

    localparam int SETTLE_CYCLES = 260;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    timespec_sleep_timer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the timer state.
    logic [31:0] model_freq;
    logic [63:0] model_ticks;
    logic [63:0] model_deadline;
    logic        model_armed;

    tst_out_t expected_results[$];
    int error_count;
    int items_sent;
    int results_seen;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(12 * 3000000);
        $display("testbench: errors");
        $finish;
    end

    function automatic logic [63:0] max_seconds(logic [31:0] freq);
        logic [63:0] f;
        logic [63:0] limit;
        begin
            f = (freq == 32'd0) ? 64'd1 : {32'd0, freq};
            limit = DIVIDEND_MAX / f;
            if (limit > {1'b0, SEC_MAX_63})
                limit = {1'b0, SEC_MAX_63};
            return limit;
        end
    endfunction

    // Advances the shadow state by one item and returns its result, if any.
    function automatic bit predict_timer(tst_in_t item, output tst_out_t res);
        logic [63:0] f;
        logic [63:0] sec;
        logic [63:0] ns;
        logic [63:0] dl;
        logic [63:0] rem;
        logic [63:0] rem_sec;
        begin
            f = (model_freq == 32'd0) ? 64'd1 : {32'd0, model_freq};
            res = '0;
            case (item.req_type)
                REQ_TICK: begin
                    model_ticks = model_ticks + 64'd1;
                    if (model_armed && model_ticks >= model_deadline) begin
                        model_armed = 1'b0;
                        res.status = ST_DONE;
                        return 1'b1;
                    end
                    return 1'b0;
                end
                REQ_SLEEP: begin
                    sec = item.req_seconds;
                    ns = {32'd0, item.req_nanoseconds};
                    if (sec[63] || sec > max_seconds(model_freq) || ns[31]
                            || ns > {32'd0, MAX_NSEC}) begin
                        res.status = ST_INVALID;
                        return 1'b1;
                    end
                    dl = {32'd0, sec[31:0]} * f + (ns * f) / {32'd0, NANOS_PER_SEC};
                    if (item.relative)
                        dl = dl + model_ticks;
                    if (dl <= model_ticks) begin
                        model_armed = 1'b0;
                        res.status = ST_DONE;
                        return 1'b1;
                    end
                    model_deadline = dl;
                    model_armed = 1'b1;
                    return 1'b0;
                end
                REQ_INTR: begin
                    if (!model_armed)
                        return 1'b0;
                    rem = (model_deadline > model_ticks) ? model_deadline - model_ticks : 64'd0;
                    rem_sec = rem / f;
                    if (rem_sec > {1'b0, SEC_MAX_63})
                        rem_sec = {1'b0, SEC_MAX_63};
                    res.status = ST_INTR;
                    res.rem_seconds = rem_sec[62:0];
                    res.rem_nanoseconds = 30'(((rem % f) * {32'd0, NANOS_PER_SEC}) / f);
                    model_armed = 1'b0;
                    return 1'b1;
                end
                default: return 1'b0;
            endcase
        end
    endfunction

    function automatic tst_in_t make_item(logic [1:0] kind, logic rel,
                                          logic [63:0] sec, logic [31:0] ns);
        tst_in_t item;
        begin
            item.req_type = kind;
            item.relative = rel;
            item.req_seconds = sec;
            item.req_nanoseconds = ns;
            return item;
        end
    endfunction

    task automatic send_item(tst_in_t item);
        tst_out_t res;
        begin
            if ($urandom_range(99) < send_idle_pct) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_data <= item;
            do @(posedge aclk); while (!s_ready);
            if (predict_timer(item, res))
                expected_results.push_back(res);
            if (item.req_type != REQ_UNUSED)
                items_sent++;
        end
    endtask

    // Stops offering items and waits until the block has nothing left to do.
    task automatic drain_block();
        begin
            s_valid <= 1'b0;
            while (expected_results.size() != 0) @(posedge aclk);
            repeat (SETTLE_CYCLES) @(posedge aclk);
        end
    endtask

    task automatic write_frequency(logic [31:0] freq);
        begin
            drain_block();
            cfg_valid <= 1'b1;
            cfg_data <= freq;
            do @(posedge aclk); while (!cfg_ready);
            cfg_valid <= 1'b0;
            model_freq = freq;
        end
    endtask

    // Mostly ticks, plus interrupts, unused items and sleeps that are mostly short.
    function automatic tst_in_t random_item();
        int pick;
        logic [63:0] sec;
        logic [31:0] ns;
        logic [63:0] limit;
        begin
            pick = $urandom_range(99);
            limit = max_seconds(model_freq);
            if (pick < 55)
                return make_item(REQ_TICK, 1'($urandom), {$urandom, $urandom}, $urandom);
            if (pick < 67)
                return make_item(REQ_INTR, 1'($urandom), {$urandom, $urandom}, $urandom);
            if (pick < 70)
                return make_item(REQ_UNUSED, 1'($urandom), {$urandom, $urandom}, $urandom);
            case ($urandom_range(9))
                0: sec = {$urandom, $urandom};
                1: sec = limit + 64'($urandom_range(1));
                2: sec = limit - 64'($urandom_range(3));
                default: sec = 64'($urandom_range(3) == 0 ? 1 : 0);
            endcase
            case ($urandom_range(9))
                0: ns = $urandom;
                1: ns = MAX_NSEC + 32'($urandom_range(1));
                default: ns = 32'($urandom_range(30000000));
            endcase
            // Small frequencies make second-sized sleeps reachable by ticks.
            if (model_freq > 32'd1000 && sec < 64'd4)
                sec = 64'd0;
            if (model_freq > 32'd1000 && ns < 32'd30000001)
                ns = 32'($urandom_range(2000));
            return make_item(REQ_SLEEP, ($urandom_range(3) != 0), sec, ns);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        tst_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, m_data);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_data.status != want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_data.status);
                    error_count++;
                end
                if (m_data.rem_seconds != want.rem_seconds) begin
                    $display("%0t: rem_seconds expected %0d actual %0d",
                             $time, want.rem_seconds, m_data.rem_seconds);
                    error_count++;
                end
                if (m_data.rem_nanoseconds != want.rem_nanoseconds) begin
                    $display("%0t: rem_nanoseconds expected %0d actual %0d",
                             $time, want.rem_nanoseconds, m_data.rem_nanoseconds);
                    error_count++;
                end
            end
        end
    end

    task automatic test_directed();
        logic [63:0] limit;
        begin
            limit = max_seconds(model_freq);
            send_item(make_item(REQ_TICK, 1'b0, 64'd0, 32'd0));
            send_item(make_item(REQ_INTR, 1'b0, 64'd0, 32'd0));
            send_item(make_item(REQ_UNUSED, 1'b1, '1, '1));
            send_item(make_item(REQ_SLEEP, 1'b1, 64'h8000_0000_0000_0000, 32'd0));
            send_item(make_item(REQ_SLEEP, 1'b1, '1, 32'd5));
            send_item(make_item(REQ_SLEEP, 1'b0, limit + 64'd1, 32'd0));
            send_item(make_item(REQ_SLEEP, 1'b1, 64'd0, 32'hFFFF_FFFF));
            send_item(make_item(REQ_SLEEP, 1'b1, 64'd0, 32'h8000_0000));
            send_item(make_item(REQ_SLEEP, 1'b1, 64'd0, NANOS_PER_SEC));
            // The largest valid request arms; an interrupt reports the time left.
            send_item(make_item(REQ_SLEEP, 1'b0, limit, MAX_NSEC));
            send_item(make_item(REQ_TICK, 1'b0, 64'd0, 32'd0));
            send_item(make_item(REQ_INTR, 1'b0, 64'd0, 32'd0));
            send_item(make_item(REQ_SLEEP, 1'b0, 64'd0, 32'd0));
            send_item(make_item(REQ_SLEEP, 1'b1, 64'd0, 32'd0));
            // A second request replaces the pending one.
            send_item(make_item(REQ_SLEEP, 1'b1, 64'd5, 32'd0));
            send_item(make_item(REQ_SLEEP, 1'b1, 64'd0, 32'd200));
            repeat (5) send_item(make_item(REQ_TICK, 1'b0, 64'd0, 32'd0));
            send_item(make_item(REQ_INTR, 1'b1, '1, '1));
            send_item(make_item(REQ_SLEEP, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF));
        end
    endtask

    task automatic test_frequency_extremes();
        logic [31:0] freqs[3];
        begin
            freqs[0] = 32'd1;
            freqs[1] = 32'hFFFF_FFFF;
            freqs[2] = FREQ_RESET;
            foreach (freqs[i]) begin
                write_frequency(freqs[i]);
                send_item(make_item(REQ_SLEEP, 1'b0, max_seconds(freqs[i]), MAX_NSEC));
                send_item(make_item(REQ_INTR, 1'b0, 64'd0, 32'd0));
                send_item(make_item(REQ_SLEEP, 1'b0, max_seconds(freqs[i]) + 64'd1, 32'd0));
                send_item(make_item(REQ_SLEEP, 1'b1, 64'd2, 32'd123456789));
                repeat (3) send_item(make_item(REQ_TICK, 1'b0, 64'd0, 32'd0));
                send_item(make_item(REQ_INTR, 1'b0, 64'd0, 32'd0));
            end
        end
    endtask

    task automatic test_random_traffic(int count);
        logic [31:0] freqs[5];
        begin
            freqs[0] = 32'd1000;
            freqs[1] = 32'd1;
            freqs[2] = 32'($urandom_range(2, 500));
            freqs[3] = 32'hFFFF_FFFF;
            freqs[4] = $urandom;
            foreach (freqs[i]) begin
                write_frequency(freqs[i]);
                repeat (count / 5) send_item(random_item());
            end
        end
    endtask

    // The receiver stalls long enough for results to back up into the input.
    task automatic test_backpressure();
        begin
            drain_block();
            hold_cycles = 2000;
            repeat (8) send_item(make_item(REQ_SLEEP, 1'b0, '1, 32'd0));
            repeat (4) send_item(make_item(REQ_SLEEP, 1'b1, 64'd0, 32'd0));
            drain_block();
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        error_count = 0;
        items_sent = 0;
        results_seen = 0;
        hold_cycles = 0;
        send_idle_pct = 25;
        recv_idle_pct = 74;
        model_freq = FREQ_RESET;
        model_ticks = '0;
        model_deadline = '0;
        model_armed = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_frequency_extremes();
        test_random_traffic(500);
        send_idle_pct = 74;
        recv_idle_pct = 25;
        test_random_traffic(500);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(500);
        drain_block();

        $display("Sent %0d ticks, sleeps and interrupts over several tick frequencies;",
                 items_sent);
        $display("checked %0d results under random idling and a long output stall.",
                 results_seen);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire
